// ===== hw/rtl/seiop_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Servo positioner package
// Command, status and register codes, field widths and reset values shared by
// the servo ease-in-out positioner.
// ----------------------------------------------------------------------------
package seiop_pkg;

	localparam int ANGLE_W    = 16;
	localparam int PULSE_W    = 12;
	localparam int TIME_W     = 16;
	localparam int PREQ_W     = 16;
	localparam int STEPS_W    = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int S_TDATA_W  = 48;
	localparam int M_TDATA_W  = 64;

	typedef enum logic [1:0] {
		MODE_INIT        = 2'd0,
		MODE_ANGLE       = 2'd1,
		MODE_ANGLE_TIMED = 2'd2,
		MODE_PULSE       = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOT_INIT = 2'd1,
		ST_DISABLED = 2'd2
	} status_t;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_ANGLE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEPS    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_ON  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_ENABLED = 3'd6;

	localparam logic signed [ANGLE_W-1:0] RST_MIN_ANGLE  = 16'sd0;
	localparam logic signed [ANGLE_W-1:0] RST_MAX_ANGLE  = 16'sd18000;
	localparam logic [PULSE_W-1:0]        RST_MIN_PULSE  = 12'd1000;
	localparam logic [PULSE_W-1:0]        RST_MAX_PULSE  = 12'd2000;
	localparam logic [STEPS_W-1:0]        RST_RAMP_STEPS = 6'd20;
	localparam logic signed [ANGLE_W-1:0] RST_ANGLE      = 16'sd9000;
	localparam logic [PULSE_W-1:0]        RST_PULSE      = 12'd1500;

endpackage
`default_nettype wire

// ===== hw/rtl/servo_ease_in_out_positioner_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Servo ease-in-out positioner
// Init, set-angle and set-pulse commands give a single result; a smooth move
// gives a series of points. One radix-2 divider of DIV_N bits, with
// DIV_N = max(28, clog2(MAX_STEPS+1) + EASE_FRAC_BITS), is shared by the
// conversions and the ramp timing of the sequencer.
// One request at a time; s_tready is high only between requests.
// Reset: registers return to defaults, servo at 9000 / 1500, not initialized.
// ----------------------------------------------------------------------------
module servo_ease_in_out_positioner_unit #(
	parameter int MAX_STEPS      = 63,
	parameter int EASE_FRAC_BITS = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// angle_request[15:0], move_time_ms[31:16], pulse_request[47:32]
	input  wire logic [seiop_pkg::S_TDATA_W-1:0]      s_tdata,
	// mode[1:0]
	input  wire logic [1:0]                           s_tuser,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// status[1:0], angle_now[17:2], angle_goal[33:18], pulse_now[45:34],
	// hold_ms[61:46], zero[63:62]
	output logic [seiop_pkg::M_TDATA_W-1:0]           m_tdata,
	output logic                                      m_tlast,
	input  wire logic                                 cfg_we,
	input  wire logic [seiop_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [seiop_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int IW    = $clog2(MAX_STEPS + 1);
	localparam int F     = EASE_FRAC_BITS;
	localparam int FW    = F + 1;
	localparam int DIV_N = (IW + F > 28) ? IW + F : 28;
	localparam int DRW   = DIV_N + 1;
	localparam int DVW   = 16;
	localparam int CW    = $clog2(DIV_N);
	localparam int MUL_W = (F + 2 > 18) ? F + 2 : 18;
	localparam int PW    = 2 * MUL_W;
	localparam logic [FW-1:0] ONE = {1'b1, {F{1'b0}}};

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_P2A_MUL, S_P2A_END, S_A2P_START, S_A2P_END,
		S_DIVP_LD, S_DIV, S_RAMP_HOLD, S_RAMP_T, S_RAMP_E1, S_RAMP_E2,
		S_RAMP_PT, S_EMIT
	} state_t;

	logic signed [15:0] min_angle_q, max_angle_q;
	logic [11:0]        min_pulse_q, max_pulse_q;
	logic [5:0]         ramp_steps_q;
	logic               smoothing_on_q, drive_enabled_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_angle_q     <= seiop_pkg::RST_MIN_ANGLE;
			max_angle_q     <= seiop_pkg::RST_MAX_ANGLE;
			min_pulse_q     <= seiop_pkg::RST_MIN_PULSE;
			max_pulse_q     <= seiop_pkg::RST_MAX_PULSE;
			ramp_steps_q    <= seiop_pkg::RST_RAMP_STEPS;
			smoothing_on_q  <= 1'b1;
			drive_enabled_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				seiop_pkg::REG_MIN_ANGLE:     min_angle_q     <= $signed(cfg_data);
				seiop_pkg::REG_MAX_ANGLE:     max_angle_q     <= $signed(cfg_data);
				seiop_pkg::REG_MIN_PULSE:     min_pulse_q     <= cfg_data[11:0];
				seiop_pkg::REG_MAX_PULSE:     max_pulse_q     <= cfg_data[11:0];
				seiop_pkg::REG_RAMP_STEPS:    ramp_steps_q    <= cfg_data[5:0];
				seiop_pkg::REG_SMOOTHING_ON:  smoothing_on_q  <= cfg_data[0];
				seiop_pkg::REG_DRIVE_ENABLED: drive_enabled_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	state_t               state_q, ret_q;
	seiop_pkg::mode_t     mode_q;
	seiop_pkg::status_t   status_q;
	logic signed [15:0]   req_q, pos_q, goal_q, start_q;
	logic [15:0]          dur_q, preq_q, hold_q;
	logic [11:0]          pulse_q;
	logic signed [16:0]   range_q;
	logic                 ready_q, ramp_q, sub_q;
	logic [IW-1:0]        steps_q, i_q;
	logic signed [PW-1:0] prod_q;
	logic [DVW-1:0]       div_d_q, div_rem_q;
	logic [DIV_N-1:0]     div_quo_q;
	logic                 div_neg_q;
	logic [CW-1:0]        div_cnt_q;
	logic                 m_tvalid_q, m_tlast_q;
	logic [seiop_pkg::M_TDATA_W-1:0] m_tdata_q;

	logic signed [16:0]   arange, csum, num_a, numc;
	logic signed [12:0]   dp;
	logic signed [15:0]   req_c, pt_c;
	logic [11:0]          pcl, num_p;
	logic [IW-1:0]        steps_sat;
	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic signed [PW-1:0] mul_p, prod_mag;
	logic [DVW:0]         rem_sh, rem_diff;
	logic                 take;
	logic [DVW-1:0]       rem_next;
	logic signed [DRW-1:0] quo_s, div_res;
	logic [DIV_N-1:0]     t_num;
	logic [FW-1:0]        t_val, u_val, sq_base, sq_f, e_val;
	logic                 t_hi;
	logic signed [17:0]   pt_step, pt;
	logic                 more_pts;
	logic [15:0]          hold_out;

	always_comb begin
		arange = 17'(max_angle_q) - 17'(min_angle_q);
		dp     = $signed({1'b0, max_pulse_q}) - $signed({1'b0, min_pulse_q});
		csum   = 17'(min_angle_q) + 17'(max_angle_q);

		if (req_q < min_angle_q)      req_c = min_angle_q;
		else if (req_q > max_angle_q) req_c = max_angle_q;
		else                          req_c = req_q;

		if (preq_q < {4'b0, min_pulse_q})      pcl = min_pulse_q;
		else if (preq_q > {4'b0, max_pulse_q}) pcl = max_pulse_q;
		else                                   pcl = preq_q[11:0];
		num_p = pulse_q - min_pulse_q;

		num_a = 17'(pos_q) - 17'(min_angle_q);
		if (num_a < 17'sd0)      numc = '0;
		else if (num_a > arange) numc = arange;
		else                     numc = num_a;

		if (ramp_steps_q == '0)                  steps_sat = IW'(1);
		else if (ramp_steps_q > 6'(MAX_STEPS))  steps_sat = IW'(MAX_STEPS);
		else                                     steps_sat = ramp_steps_q[IW-1:0];

		t_num   = DIV_N'(i_q) << F;
		t_val   = div_quo_q[FW-1:0];
		t_hi    = t_val[F] | t_val[F-1];
		u_val   = ONE - t_val;
		sq_base = t_hi ? u_val : t_val;
		sq_f    = prod_q[F-1 +: FW];
		e_val   = sub_q ? ONE - sq_f : sq_f;

		pt_step = prod_q[F +: 18];
		pt      = 18'(start_q) + pt_step;
		if (pt < 18'(min_angle_q))      pt_c = min_angle_q;
		else if (pt > 18'(max_angle_q)) pt_c = max_angle_q;
		else                            pt_c = pt[15:0];

		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_A2P_START: begin
				mul_a = MUL_W'(numc);
				mul_b = MUL_W'(dp);
			end
			S_P2A_MUL: begin
				mul_a = MUL_W'(num_p);
				mul_b = MUL_W'(arange);
			end
			S_RAMP_E1: begin
				mul_a = MUL_W'(sq_base);
				mul_b = MUL_W'(sq_base);
			end
			S_RAMP_E2: begin
				mul_a = MUL_W'(range_q);
				mul_b = MUL_W'(e_val);
			end
			default: ;
		endcase
		mul_p    = mul_a * mul_b;
		prod_mag = prod_q[PW-1] ? -prod_q : prod_q;

		rem_sh   = {div_rem_q, div_quo_q[DIV_N-1]};
		take     = rem_sh >= {1'b0, div_d_q};
		rem_diff = rem_sh - {1'b0, div_d_q};
		rem_next = take ? rem_diff[DVW-1:0] : rem_sh[DVW-1:0];
		quo_s    = $signed({1'b0, div_quo_q});
		div_res  = div_neg_q ? (~quo_s + DRW'(div_rem_q == '0)) : quo_s;

		more_pts = ramp_q && (i_q != steps_q);
		hold_out = more_pts ? hold_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ret_q      <= S_IDLE;
			mode_q     <= seiop_pkg::MODE_INIT;
			status_q   <= seiop_pkg::ST_OK;
			req_q      <= '0;
			dur_q      <= '0;
			preq_q     <= '0;
			pos_q      <= seiop_pkg::RST_ANGLE;
			goal_q     <= seiop_pkg::RST_ANGLE;
			pulse_q    <= seiop_pkg::RST_PULSE;
			ready_q    <= 1'b0;
			ramp_q     <= 1'b0;
			sub_q      <= 1'b0;
			start_q    <= '0;
			range_q    <= '0;
			hold_q     <= '0;
			steps_q    <= '0;
			i_q        <= '0;
			prod_q     <= '0;
			div_d_q    <= '0;
			div_rem_q  <= '0;
			div_quo_q  <= '0;
			div_neg_q  <= 1'b0;
			div_cnt_q  <= '0;
			m_tvalid_q <= 1'b0;
			m_tlast_q  <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != S_EMIT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						mode_q   <= seiop_pkg::mode_t'(s_tuser);
						req_q    <= $signed(s_tdata[15:0]);
						dur_q    <= s_tdata[31:16];
						preq_q   <= s_tdata[47:32];
						status_q <= seiop_pkg::ST_OK;
						state_q  <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					case (mode_q)
						seiop_pkg::MODE_INIT: begin
							pos_q   <= csum[16:1];
							goal_q  <= csum[16:1];
							ready_q <= 1'b1;
							state_q <= S_A2P_START;
						end
						seiop_pkg::MODE_PULSE: begin
							if (!ready_q) begin
								status_q <= seiop_pkg::ST_NOT_INIT;
								state_q  <= S_EMIT;
							end else begin
								pulse_q <= pcl;
								if (dp <= 13'sd0) begin
									pos_q   <= min_angle_q;
									goal_q  <= min_angle_q;
									state_q <= S_EMIT;
								end else begin
									state_q <= S_P2A_MUL;
								end
							end
						end
						default: begin
							if (!ready_q) begin
								status_q <= seiop_pkg::ST_NOT_INIT;
								state_q  <= S_EMIT;
							end else if (!drive_enabled_q) begin
								status_q <= seiop_pkg::ST_DISABLED;
								state_q  <= S_EMIT;
							end else begin
								goal_q <= req_c;
								if (mode_q == seiop_pkg::MODE_ANGLE || dur_q == '0 ||
								    !smoothing_on_q) begin
									pos_q   <= req_c;
									state_q <= S_A2P_START;
								end else begin
									start_q   <= pos_q;
									range_q   <= 17'(req_c) - 17'(pos_q);
									steps_q   <= steps_sat;
									i_q       <= '0;
									ramp_q    <= 1'b1;
									div_quo_q <= DIV_N'(dur_q);
									div_d_q   <= DVW'(steps_sat);
									div_rem_q <= '0;
									div_neg_q <= 1'b0;
									div_cnt_q <= '0;
									ret_q     <= S_RAMP_HOLD;
									state_q   <= S_DIV;
								end
							end
						end
					endcase
				end
				S_P2A_MUL: begin
					prod_q  <= mul_p;
					div_d_q <= DVW'(dp[11:0]);
					ret_q   <= S_P2A_END;
					state_q <= S_DIVP_LD;
				end
				S_P2A_END: begin
					pos_q   <= min_angle_q + $signed(div_res[15:0]);
					goal_q  <= min_angle_q + $signed(div_res[15:0]);
					state_q <= S_EMIT;
				end
				S_A2P_START: begin
					if (arange <= 17'sd0) begin
						pulse_q <= min_pulse_q;
						state_q <= S_EMIT;
					end else begin
						prod_q  <= mul_p;
						div_d_q <= arange[15:0];
						ret_q   <= S_A2P_END;
						state_q <= S_DIVP_LD;
					end
				end
				S_A2P_END: begin
					pulse_q <= min_pulse_q + div_res[11:0];
					state_q <= S_EMIT;
				end
				S_DIVP_LD: begin
					div_quo_q <= prod_mag[DIV_N-1:0];
					div_neg_q <= prod_q[PW-1];
					div_rem_q <= '0;
					div_cnt_q <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					div_quo_q <= {div_quo_q[DIV_N-2:0], take};
					div_rem_q <= rem_next;
					div_cnt_q <= div_cnt_q + CW'(1);
					if (div_cnt_q == CW'(DIV_N - 1)) begin
						state_q <= ret_q;
					end
				end
				S_RAMP_HOLD: begin
					hold_q  <= div_quo_q[15:0];
					state_q <= S_RAMP_T;
				end
				S_RAMP_T: begin
					div_quo_q <= t_num;
					div_d_q   <= DVW'(steps_q);
					div_rem_q <= '0;
					div_neg_q <= 1'b0;
					div_cnt_q <= '0;
					ret_q     <= S_RAMP_E1;
					state_q   <= S_DIV;
				end
				S_RAMP_E1: begin
					prod_q  <= mul_p;
					sub_q   <= t_hi;
					state_q <= S_RAMP_E2;
				end
				S_RAMP_E2: begin
					prod_q  <= mul_p;
					state_q <= S_RAMP_PT;
				end
				S_RAMP_PT: begin
					pos_q   <= pt_c;
					state_q <= S_A2P_START;
				end
				S_EMIT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tlast_q  <= !more_pts;
						m_tdata_q  <= {2'b00, hold_out, pulse_q, goal_q, pos_q, status_q};
						if (more_pts) begin
							i_q     <= i_q + IW'(1);
							state_q <= S_RAMP_T;
						end else begin
							ramp_q  <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while a request was in progress");

	a_step_index: assert property (@(posedge clk) disable iff (!arst_n)
		ramp_q |-> (steps_q != '0 && i_q <= steps_q))
		else $error("ramp point index beyond step count");

	a_nonlast_in_ramp: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> ramp_q)
		else $error("non-final result outside a smooth move");

	a_div_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_rem_q < div_d_q))
		else $error("divider remainder not below divisor");

endmodule
`default_nettype wire
